@@ src/gbf_pkg.sv @@
// shared types and constants for the glob basename filter
package gbf_pkg;

	localparam int PATTERN_MAX_DEF = 32;

	// input item kinds
	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_PATH   = 2'd2;

	// configuration register indexes
	localparam int          CFG_IDX_W       = 3;
	localparam logic [2:0]  CFG_NAME_EN     = 3'd0;
	localparam logic [2:0]  CFG_TYPE_EN     = 3'd1;
	localparam logic [2:0]  CFG_WANTED_TYPE = 3'd2;
	localparam logic [2:0]  CFG_MINDEPTH_EN = 3'd3;
	localparam logic [2:0]  CFG_MIN_DEPTH   = 3'd4;

	// special pattern and path bytes
	localparam logic [7:0] CH_ESC   = 8'h5C;
	localparam logic [7:0] CH_ANY   = 8'h3F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		logic       is_star;
		logic       is_any;
		logic [7:0] lit;
	} token_t;

	typedef struct packed {
		logic clear;
		logic append;
	} pat_op_t;

	typedef struct packed {
		logic advance;
		logic slash;
		logic restart;
	} match_op_t;

endpackage

@@ src/gbf_pattern.sv @@
// pattern token store with escape, overflow and restart-set tracking
module gbf_pattern #(
	parameter int PatternMax = gbf_pkg::PATTERN_MAX_DEF,
	localparam int CntW = $clog2(PatternMax + 1),
	localparam int IdxW = (PatternMax > 1) ? $clog2(PatternMax) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gbf_pkg::pat_op_t       op,
	input  logic [7:0]             byte_value,
	output gbf_pkg::token_t        tokens [PatternMax],
	output logic [CntW-1:0]        count,
	output logic                   overflow,
	output logic [PatternMax:0]    restart_set,
	output logic [PatternMax:0]    restart_next
);
	import gbf_pkg::*;

	token_t                tok_q [PatternMax];
	logic [CntW-1:0]       count_q, count_d, cnt_inc;
	logic                  esc_q, esc_d;
	logic                  ovf_q, ovf_d;
	logic [PatternMax:0]   rs_q, rs_d;
	logic                  wr_en;
	logic [CntW-1:0]       wr_addr;
	token_t                wr_tok;

	assign cnt_inc = count_q + CntW'(1);

	always_comb begin
		count_d        = count_q;
		esc_d          = esc_q;
		ovf_d          = ovf_q;
		rs_d           = rs_q;
		wr_en          = 1'b0;
		wr_addr        = count_q;
		wr_tok.is_star = (byte_value == CH_STAR);
		wr_tok.is_any  = (byte_value == CH_ANY);
		wr_tok.lit     = byte_value;
		if (op.clear) begin
			count_d = '0;
			esc_d   = 1'b0;
			ovf_d   = 1'b0;
			rs_d    = (PatternMax + 1)'(1);
		end else if (op.append && !ovf_q) begin
			if (esc_q) begin
				// escaped byte replaces the pending backslash literal
				esc_d          = 1'b0;
				wr_tok.is_star = 1'b0;
				wr_tok.is_any  = 1'b0;
				if (count_q != '0) begin
					wr_en   = 1'b1;
					wr_addr = count_q - CntW'(1);
				end
			end else if (count_q == CntW'(PatternMax)) begin
				ovf_d = 1'b1;
			end else begin
				wr_en   = 1'b1;
				count_d = cnt_inc;
				esc_d   = (byte_value == CH_ESC);
				// a star right after a run of leading stars extends the restart set
				if (wr_tok.is_star && rs_q[count_q]) begin
					rs_d[cnt_inc] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			esc_q   <= 1'b0;
			ovf_q   <= 1'b0;
			rs_q    <= (PatternMax + 1)'(1);
		end else begin
			count_q <= count_d;
			esc_q   <= esc_d;
			ovf_q   <= ovf_d;
			rs_q    <= rs_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tok_q[wr_addr[IdxW-1:0]] <= wr_tok;
		end
	end

	assign tokens       = tok_q;
	assign count        = count_q;
	assign overflow     = ovf_q;
	assign restart_set  = rs_q;
	assign restart_next = rs_d;

endmodule

@@ src/gbf_matcher.sv @@
// active pattern position set and per-byte update
module gbf_matcher #(
	parameter int PatternMax = gbf_pkg::PATTERN_MAX_DEF,
	localparam int CntW = $clog2(PatternMax + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gbf_pkg::match_op_t     op,
	input  logic [7:0]             byte_value,
	input  gbf_pkg::token_t        tokens [PatternMax],
	input  logic [CntW-1:0]        count,
	input  logic                   overflow,
	input  logic [PatternMax:0]    restart_set,
	input  logic [PatternMax:0]    restart_next,
	output logic                   match
);
	import gbf_pkg::*;

	logic [PatternMax:0]   act_q;
	logic [PatternMax:0]   step_v, star_m, gen_v, carry_v, adv, eval_v;
	logic [PatternMax+1:0] sum;

	// one byte step over every live position
	always_comb begin
		step_v = '0;
		star_m = '0;
		for (int i = 0; i < PatternMax; i++) begin
			if (CntW'(i) < count) begin
				star_m[i] = tokens[i].is_star;
				if (act_q[i]) begin
					if (tokens[i].is_star) begin
						step_v[i] = 1'b1;
					end else if (tokens[i].is_any || (tokens[i].lit == byte_value)) begin
						step_v[i+1] = 1'b1;
					end
				end
			end
		end
	end

	// star closure as a carry chain: a set bit ripples up through star positions
	assign gen_v   = step_v & star_m;
	assign sum     = {1'b0, star_m} + {1'b0, gen_v};
	assign carry_v = sum[PatternMax:0] ^ star_m ^ gen_v;
	assign adv     = step_v | carry_v;

	assign eval_v = op.slash ? restart_set : adv;
	assign match  = eval_v[count] & ~overflow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= (PatternMax + 1)'(1);
		end else if (op.restart || op.slash) begin
			act_q <= restart_next;
		end else if (op.advance) begin
			act_q <= adv;
		end
	end

endmodule

@@ src/glob_basename_filter_unit.sv @@
// glob basename filter: pattern load, basename matching and print decision
//
// Pattern bytes and path bytes share one input stream. One item is taken per
// clock cycle; a result is registered in the result register after the last
// path byte has passed the input register. The active-position update handles
// each byte over all pattern positions, with a single carry chain for star
// closure. The input stalls only while a result waits for its transfer. There
// is no clearing pass after reset. Configuration writes are taken at any time.
module glob_basename_filter_unit #(
	parameter int PatternMax = gbf_pkg::PATTERN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic [7:0]                     byte_value,
	input  logic                           last,
	input  logic [6:0]                     depth,
	input  logic [1:0]                     entry_type,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           print,
	output logic                           name_match,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [6:0]                     cfg_data
);
	import gbf_pkg::*;

	localparam int CntW = $clog2(PatternMax + 1);

	logic                valid_s1;
	logic [1:0]          kind_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic [6:0]          depth_s1;
	logic [1:0]          type_s1;
	logic                go;
	logic                is_path, is_slash, emit;
	pat_op_t             pat_op;
	match_op_t           match_op;
	token_t              tokens [PatternMax];
	logic [CntW-1:0]     tok_count;
	logic                pat_ovf;
	logic [PatternMax:0] rs_set, rs_next;
	logic                match_c, pass_c;
	logic                out_valid_q, print_q, match_q;
	logic                name_en_q, type_en_q, mindepth_en_q;
	logic [1:0]          wanted_type_q;
	logic [6:0]          min_depth_q;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_en_q     <= 1'b0;
			type_en_q     <= 1'b0;
			wanted_type_q <= 2'd0;
			mindepth_en_q <= 1'b0;
			min_depth_q   <= 7'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NAME_EN:     name_en_q     <= cfg_data[0];
				CFG_TYPE_EN:     type_en_q     <= cfg_data[0];
				CFG_WANTED_TYPE: wanted_type_q <= cfg_data[1:0];
				CFG_MINDEPTH_EN: mindepth_en_q <= cfg_data[0];
				CFG_MIN_DEPTH:   min_depth_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign go       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			byte_s1  <= byte_value;
			last_s1  <= last;
			depth_s1 <= depth;
			type_s1  <= entry_type;
		end
	end

	// item decode
	assign is_path  = go && (kind_s1 == KIND_PATH);
	assign is_slash = (byte_s1 == CH_SLASH);
	assign emit     = is_path && last_s1;

	assign pat_op.clear  = go && (kind_s1 == KIND_CLEAR);
	assign pat_op.append = go && (kind_s1 == KIND_APPEND);

	assign match_op.advance = is_path && !is_slash;
	assign match_op.slash   = is_path && is_slash;
	assign match_op.restart = pat_op.clear || pat_op.append || emit;

	gbf_pattern #(
		.PatternMax(PatternMax)
	) u_pattern (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (pat_op),
		.byte_value   (byte_s1),
		.tokens       (tokens),
		.count        (tok_count),
		.overflow     (pat_ovf),
		.restart_set  (rs_set),
		.restart_next (rs_next)
	);

	gbf_matcher #(
		.PatternMax(PatternMax)
	) u_matcher (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (match_op),
		.byte_value   (byte_s1),
		.tokens       (tokens),
		.count        (tok_count),
		.overflow     (pat_ovf),
		.restart_set  (rs_set),
		.restart_next (rs_next),
		.match        (match_c)
	);

	// print decision
	assign pass_c = !(mindepth_en_q && (depth_s1 < min_depth_q))
		&& !(name_en_q && !match_c)
		&& !(type_en_q && (type_s1 != wanted_type_q));

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			print_q <= pass_c;
			match_q <= match_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign print      = print_q;
	assign name_match = match_q;

endmodule

@@ dv/glob_basename_filter_checker.sv @@
// decision checker for the glob basename filter: predicts print decisions and compares them
module gbf_decision_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [7:0]                    byte_value,
	input  logic                          last,
	input  logic [6:0]                    depth,
	input  logic [1:0]                    entry_type,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          print,
	input  logic                          name_match,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [gbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [6:0]                    cfg_data,
	output int                            outstanding,
	output int                            mismatches
);
	import gbf_pkg::*;

	localparam int PM = PATTERN_MAX_DEF;

	typedef struct packed {
		logic print;
		logic name_match;
	} decision_t;

	token_t      pat_tok [PM];
	int          tok_count;
	logic        esc_pending;
	logic        pat_overflow;
	logic [PM:0] active;

	logic        reg_name_en;
	logic        reg_type_en;
	logic [1:0]  reg_wanted_type;
	logic        reg_mindepth_en;
	logic [6:0]  reg_min_depth;

	decision_t   expected_decisions [$];
	decision_t   oldest;

	task automatic report_mismatch(input string msg);
		$display("[%0t] decision mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic [PM:0] close_stars(input logic [PM:0] v);
		for (int i = 0; i < PM; i++) begin
			if (i < tok_count && v[i] && pat_tok[i].is_star)
				v[i + 1] = 1'b1;
		end
		return v;
	endfunction

	function automatic logic [PM:0] start_positions();
		logic [PM:0] v;
		v = '0;
		v[0] = 1'b1;
		return close_stars(v);
	endfunction

	function automatic logic [PM:0] step_positions(input logic [7:0] c);
		logic [PM:0] nxt;
		nxt = '0;
		for (int i = 0; i < PM; i++) begin
			if (i < tok_count && active[i]) begin
				if (pat_tok[i].is_star)
					nxt[i] = 1'b1;
				else if (pat_tok[i].is_any || pat_tok[i].lit == c)
					nxt[i + 1] = 1'b1;
			end
		end
		return close_stars(nxt);
	endfunction

	task automatic add_token(input token_t tok);
		if (tok_count >= PM) begin
			pat_overflow = 1'b1;
		end else begin
			pat_tok[tok_count] = tok;
			tok_count++;
		end
	endtask

	task automatic take_pattern_byte(input logic [7:0] b);
		token_t tok;
		tok.is_star = (b == CH_STAR);
		tok.is_any  = (b == CH_ANY);
		tok.lit     = b;
		if (!pat_overflow) begin
			if (esc_pending) begin
				// byte after a backslash is always a literal
				pat_tok[tok_count - 1].is_star = 1'b0;
				pat_tok[tok_count - 1].is_any  = 1'b0;
				pat_tok[tok_count - 1].lit     = b;
				esc_pending = 1'b0;
			end else begin
				add_token(tok);
				if (b == CH_ESC && !pat_overflow)
					esc_pending = 1'b1;
			end
		end
	endtask

	task automatic apply_item(input logic [1:0] k, input logic [7:0] b, input logic lst,
			input logic [6:0] dep, input logic [1:0] et);
		decision_t d;
		case (k)
			KIND_CLEAR: begin
				tok_count    = 0;
				esc_pending  = 1'b0;
				pat_overflow = 1'b0;
				active       = start_positions();
			end
			KIND_APPEND: begin
				take_pattern_byte(b);
				active = start_positions();
			end
			KIND_PATH: begin
				if (b == CH_SLASH)
					active = start_positions();
				else
					active = step_positions(b);
				if (lst) begin
					d.name_match = !pat_overflow && active[tok_count];
					d.print      = 1'b1;
					if (reg_mindepth_en && dep < reg_min_depth)
						d.print = 1'b0;
					if (reg_name_en && !d.name_match)
						d.print = 1'b0;
					if (reg_type_en && et != reg_wanted_type)
						d.print = 1'b0;
					expected_decisions.push_back(d);
					active = start_positions();
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_count       = 0;
			esc_pending     = 1'b0;
			pat_overflow    = 1'b0;
			active          = start_positions();
			reg_name_en     = 1'b0;
			reg_type_en     = 1'b0;
			reg_wanted_type = 2'd0;
			reg_mindepth_en = 1'b0;
			reg_min_depth   = 7'd0;
			mismatches      = 0;
			expected_decisions.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_decisions.size() == 0) begin
					report_mismatch($sformatf("result transfer with none expected (print %0b match %0b)",
						print, name_match));
				end else begin
					oldest = expected_decisions.pop_front();
					if (print !== oldest.print)
						report_mismatch($sformatf("print got %0b want %0b", print, oldest.print));
					if (name_match !== oldest.name_match)
						report_mismatch($sformatf("name_match got %0b want %0b",
							name_match, oldest.name_match));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NAME_EN:     reg_name_en     = cfg_data[0];
					CFG_TYPE_EN:     reg_type_en     = cfg_data[0];
					CFG_WANTED_TYPE: reg_wanted_type = cfg_data[1:0];
					CFG_MINDEPTH_EN: reg_mindepth_en = cfg_data[0];
					CFG_MIN_DEPTH:   reg_min_depth   = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				apply_item(kind, byte_value, last, depth, entry_type);
			outstanding <= expected_decisions.size();
		end
	end

endmodule

@@ dv/tb_glob_basename_filter_unit.sv @@
// testbench top for the glob basename filter: stimulus, flow control and verdict
module tb_glob_basename_filter_unit;
	import gbf_pkg::*;

	localparam logic [1:0] KIND_UNUSED    = 2'd3;
	localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;
	localparam int         ITEM_TARGET    = 550;
	localparam int         PHASE_ITEMS    = 70;
	localparam int         HOLD_CYCLES    = 400;
	localparam int         SETTLE_CYCLES  = 6;
	localparam int         RUN_LIMIT      = 6000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           kind = KIND_CLEAR;
	logic [7:0]           byte_value = 8'd0;
	logic                 last = 1'b0;
	logic [6:0]           depth = 7'd0;
	logic [1:0]           entry_type = 2'd0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 print;
	logic                 name_match;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_NAME_EN;
	logic [6:0]           cfg_data = 7'd0;

	int                   outstanding;
	int                   mismatches;
	int                   items_sent = 0;
	int                   holds_asked = 0;
	bit                   calm = 1'b0;
	bit                   burst = 1'b0;
	logic [7:0]           glob_text [$];

	glob_basename_filter_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.byte_value (byte_value),
		.last       (last),
		.depth      (depth),
		.entry_type (entry_type),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.print      (print),
		.name_match (name_match),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	gbf_decision_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.byte_value  (byte_value),
		.last        (last),
		.depth       (depth),
		.entry_type  (entry_type),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.print       (print),
		.name_match  (name_match),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#(RUN_LIMIT);
		$display("glob_basename_filter_unit regression: fail");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] glob_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 8'h61 + 8'($urandom_range(0, 2));
		if (r < 50)
			return CH_STAR;
		if (r < 57)
			return CH_ANY;
		if (r < 62)
			return CH_ESC;
		if (r < 65)
			return CH_SLASH;
		return 8'($urandom_range(0, 255));
	endfunction

	// any byte except a slash, for wildcard positions
	function automatic logic [7:0] name_byte();
		logic [7:0] b;
		if ($urandom_range(0, 1) == 0)
			b = 8'h61 + 8'($urandom_range(0, 2));
		else
			b = 8'($urandom_range(0, 255));
		if (b == CH_SLASH)
			b = 8'h7A;
		return b;
	endfunction

	// receiver: random ready runs, plus a long hold whenever one is asked for
	initial begin
		int hold_left;
		int run_left;
		int holds_served;
		logic run_level;
		hold_left = 0;
		run_left = 0;
		holds_served = 0;
		run_level = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served != holds_asked) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					run_level = !run_level;
					if (!run_level)
						run_left = pick_gap();
					if (run_left == 0) begin
						run_level = 1'b1;
						run_left = $urandom_range(1, 40);
					end
				end
				run_left--;
				out_ready <= run_level;
			end
		end
	end

	task automatic send_item(input logic [1:0] k, input logic [7:0] b, input logic l,
			input logic [6:0] d, input logic [1:0] t);
		int gap;
		gap = (calm || burst) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		byte_value <= b;
		last       <= l;
		depth      <= d;
		entry_type <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (k != KIND_UNUSED)
			items_sent++;
	endtask

	task automatic send_path(input logic [7:0] b, input logic l);
		send_item(KIND_PATH, b, l, 7'($urandom_range(0, 64)), 2'($urandom_range(0, 3)));
	endtask

	task automatic send_append(input logic [7:0] b);
		glob_text.push_back(b);
		send_item(KIND_APPEND, b, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 64)),
			2'($urandom_range(0, 3)));
	endtask

	task automatic load_glob(input int n);
		glob_text.delete();
		send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			7'($urandom_range(0, 64)), 2'($urandom_range(0, 3)));
		repeat (n)
			send_append(glob_byte());
	endtask

	// path whose basename follows the current glob, optionally with one byte spoiled
	task automatic send_name(input bit faithful);
		logic [7:0] name_q [$];
		logic [7:0] c;
		int i;
		repeat ($urandom_range(0, 2)) begin
			repeat ($urandom_range(0, 3))
				name_q.push_back(name_byte());
			name_q.push_back(CH_SLASH);
		end
		i = 0;
		while (i < glob_text.size()) begin
			c = glob_text[i];
			if (c == CH_ESC) begin
				if (i + 1 < glob_text.size()) begin
					i++;
					name_q.push_back(glob_text[i]);
				end else begin
					name_q.push_back(CH_ESC);
				end
			end else if (c == CH_ANY) begin
				name_q.push_back(name_byte());
			end else if (c == CH_STAR) begin
				repeat ($urandom_range(0, 3))
					name_q.push_back(name_byte());
			end else begin
				name_q.push_back(c);
			end
			i++;
		end
		if (!faithful && name_q.size() > 0)
			name_q[$urandom_range(0, name_q.size() - 1)] = glob_byte();
		if (name_q.size() == 0)
			name_q.push_back(CH_SLASH);
		foreach (name_q[j])
			send_path(name_q[j], j == name_q.size() - 1);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_filters(input logic ne, input logic te, input logic [1:0] wt,
			input logic me, input logic [6:0] md);
		logic [5:0] junk;
		junk = $urandom_range(0, 63);
		write_reg(CFG_NAME_EN, {junk, ne});
		junk = $urandom_range(0, 63);
		write_reg(CFG_TYPE_EN, {junk, te});
		junk = $urandom_range(0, 63);
		write_reg(CFG_WANTED_TYPE, {junk[4:0], wt});
		junk = $urandom_range(0, 63);
		write_reg(CFG_MINDEPTH_EN, {junk, me});
		write_reg(CFG_MIN_DEPTH, md);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase;
		int phase_end;
		int r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, filters at reset values
		send_item(KIND_UNUSED, 8'hFF, 1'b1, 7'd64, 2'd3);
		send_path(CH_SLASH, 1'b1);
		load_glob(0);
		send_append(8'h61);
		send_append(CH_STAR);
		send_append(CH_ANY);
		send_append(CH_ESC);
		send_append(CH_STAR);
		send_append(CH_ESC);
		send_path(CH_SLASH, 1'b0);
		send_path(8'h61, 1'b0);
		send_path(8'h62, 1'b0);
		send_path(CH_STAR, 1'b0);
		send_item(KIND_PATH, CH_ESC, 1'b1, 7'd64, 2'd2);
		send_item(KIND_PATH, 8'hFF, 1'b1, 7'd64, 2'd3);
		send_item(KIND_PATH, 8'h00, 1'b1, 7'd0, 2'd1);
		send_path(8'h61, 1'b0);
		send_append(8'h80);
		send_path(CH_SLASH, 1'b1);
		send_name(1'b1);
		drain();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: set_filters(1'b1, 1'b0, 2'd0, 1'b0, 7'd0);
				1: set_filters(1'b1, 1'b1, 2'd3, 1'b1, 7'd64);
				2: set_filters(1'b1, 1'b1, 2'd0, 1'b1, 7'd0);
				3: begin
					write_reg(CFG_UNUSED_IDX, 7'($urandom_range(0, 127)));
					set_filters(1'b0, 1'b1, 2'd2, 1'b1, 7'd32);
				end
				default: set_filters(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					7'($urandom_range(0, 64)));
			endcase
			if (phase == 1 || phase == 5) begin
				holds_asked <= holds_asked + 1;
				burst = 1'b1;
			end
			load_glob(phase == 0 ? 33 : $urandom_range(0, 6));
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				calm = ($urandom_range(0, 4) == 0);
				r = $urandom_range(0, 99);
				if (r < 10) begin
					load_glob($urandom_range(1, 8));
				end else if (r < 14) begin
					load_glob($urandom_range(30, 36));
				end else if (r < 75) begin
					send_name($urandom_range(0, 3) != 0);
				end else if (r < 85) begin
					repeat ($urandom_range(0, 7))
						send_path(glob_byte(), 1'b0);
					send_path(glob_byte(), 1'b1);
				end else if (r < 92) begin
					send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						7'($urandom_range(0, 64)), 2'($urandom_range(0, 3)));
				end else begin
					// pattern change in the middle of a path
					repeat ($urandom_range(1, 3))
						send_path(name_byte(), 1'b0);
					send_append(glob_byte());
					send_name(1'b1);
				end
			end
			burst = 1'b0;
			calm = 1'b0;
			drain();
			phase++;
		end

		@(negedge clk);
		if (mismatches == 0)
			$display("glob_basename_filter_unit regression: pass");
		else
			$display("glob_basename_filter_unit regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
src/gbf_pkg.sv
src/gbf_pattern.sv
src/gbf_matcher.sv
src/glob_basename_filter_unit.sv
dv/glob_basename_filter_checker.sv
dv/tb_glob_basename_filter_unit.sv
